// ===== hw/rtl/fmtg_pkg.sv =====
`timescale 1ns / 1ps
// fmtg_pkg: shared widths, register indexes and the sine table builder of the fm tone generator
package fmtg_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_INDEX    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 3'd4;

    // register and field widths
    localparam int STEP_W   = 32;
    localparam int INDEX_W  = 32;
    localparam int AMP_W    = 17;
    localparam int SCOUNT_W = 24;
    localparam int SINE_W   = 16;

    localparam logic [AMP_W-1:0] AMP_RESET = 17'd65536;

    // serial multiplier: signed multiplicand, unsigned multiplier shifted out lsb first
    localparam int MCAND_W  = 33;
    localparam int MPLIER_W = 17;
    localparam int PROD_W   = MCAND_W + MPLIER_W;

    // phase offset is index * sine scaled down by 2^(OFFSET_SHIFT - PHASE_BITS)
    localparam int OFFSET_SHIFT = 39;

    // output rounding and saturation
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd32768;
    localparam logic signed [PROD_W-1:0] SAT_MAX    = 50'sd32767;
    localparam logic signed [PROD_W-1:0] SAT_MIN    = -50'sd32768;
    localparam int ROUND_SHIFT = 16;

    // fixed-point constants for the table builder
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // one table entry: degree-11 taylor sine in q30, rounded to q1.15
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k,
                                                           input int unsigned tbl_bits);
        logic [63:0] q;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [SINE_W-1:0] v16;
        q    = 64'd1 << (tbl_bits - 2);
        quad = (64'(k) >> (tbl_bits - 2)) & 64'd3;
        r    = 64'(k) & (q - 64'd1);
        u    = quad[0] ? (q - r) : r;
        x    = (u * HALF_PI_Q30) >> (tbl_bits - 2);
        x2   = (x * x) >> 30;
        t    = ONE_Q30 - x2 / 64'd110;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t    = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s    = (x * t) >> 30;
        v    = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        v16 = v[SINE_W-1:0];
        return quad[1] ? -v16 : v16;
    endfunction

endpackage

// ===== hw/rtl/fmtg_sine_rom.sv =====
`timescale 1ns / 1ps
// fmtg_sine_rom: full-wave sine table with registered read
module fmtg_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                   clk,
    input  logic [SINE_TABLE_BITS-1:0]             addr,
    output logic signed [fmtg_pkg::SINE_W-1:0]     data
);

    localparam int DEPTH = 1 << SINE_TABLE_BITS;

    logic signed [fmtg_pkg::SINE_W-1:0] rom_mem [DEPTH];
    logic signed [fmtg_pkg::SINE_W-1:0] data_reg;

    // table contents fixed at elaboration
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        assign rom_mem[k] = fmtg_pkg::sine_entry(32'(k), 32'(SINE_TABLE_BITS));
    end

    // registered read
    always_ff @(posedge clk)
    begin
        data_reg <= rom_mem[addr];
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/fmtg_serial_mult.sv =====
`timescale 1ns / 1ps
// fmtg_serial_mult: bit-serial shift-and-add multiplier, one multiplier bit per cycle
module fmtg_serial_mult (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [fmtg_pkg::MCAND_W-1:0]     mcand,
    input  logic [fmtg_pkg::MPLIER_W-1:0]           mplier,
    output logic                                    done,
    output logic signed [fmtg_pkg::PROD_W-1:0]      product
);

    localparam int MC_W   = fmtg_pkg::MCAND_W;
    localparam int MP_W   = fmtg_pkg::MPLIER_W;
    localparam int CNT_W  = $clog2(MP_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MP_W - 1);

    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [CNT_W-1:0]        step_reg;
    logic [CNT_W-1:0]        step_next;
    logic signed [MC_W-1:0]  mcand_reg;
    logic signed [MC_W-1:0]  mcand_next;
    logic signed [MC_W-1:0]  hi_reg;
    logic signed [MC_W-1:0]  hi_next;
    logic [MP_W-1:0]         lo_reg;
    logic [MP_W-1:0]         lo_next;
    logic signed [MC_W:0]    addend;
    logic signed [MC_W:0]    sum;

    // partial sum: upper half plus multiplicand when the current bit is set
    assign addend = lo_reg[0] ? {mcand_reg[MC_W-1], mcand_reg} : '0;
    assign sum    = {hi_reg[MC_W-1], hi_reg} + addend;

    // sequencing and shift
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplier;
        end
        else if (busy_reg)
        begin
            hi_next   = sum[MC_W:1];
            lo_next   = {sum[0], lo_reg[MP_W-1:1]};
            step_next = step_reg + CNT_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hw/rtl/fm_tone_generator.sv =====
`timescale 1ns / 1ps
// fm_tone_generator: fm sine tone by direct digital synthesis, at most one sample word per tick
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_stall        restart
//   out      output     out_valid / out_stall      sample, last
//   cfg      input      cfg_wr_en                  cfg_index, cfg_data
//
// a tick that yields a sample passes from acceptance to the result word through the states
// look_m, issue_m, wait_m, sum, look_c, issue_c, wait_c and out, with two 17-step bit-serial
// multiplies sharing one shift-and-add unit; the next tick can be taken in the cycle after out is left
// a tick that yields nothing is done in the cycle it is taken
// reset is asynchronous and active low; it leaves the block idle until a restart tick
// a stalled result word holds in the output register while the next tick is worked on
module fm_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int COUNT_BITS      = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [15:0]                     sample,
    output logic                                   last,
    input  logic                                   cfg_wr_en,
    input  logic [fmtg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fmtg_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int MC_W  = fmtg_pkg::MCAND_W;
    localparam int MP_W  = fmtg_pkg::MPLIER_W;
    localparam int PR_W  = fmtg_pkg::PROD_W;
    localparam int SN_W  = fmtg_pkg::SINE_W;
    localparam int OFF_W = PR_W + PHASE_BITS;
    localparam int OFF_LO = fmtg_pkg::OFFSET_SHIFT;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOOK_M  = 9'b000000010,
        S_ISSUE_M = 9'b000000100,
        S_WAIT_M  = 9'b000001000,
        S_SUM     = 9'b000010000,
        S_LOOK_C  = 9'b000100000,
        S_ISSUE_C = 9'b001000000,
        S_WAIT_C  = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    // configuration registers
    logic [fmtg_pkg::STEP_W-1:0]   carrier_step_reg;
    logic [fmtg_pkg::STEP_W-1:0]   mod_step_reg;
    logic [fmtg_pkg::INDEX_W-1:0]  mod_index_reg;
    logic [fmtg_pkg::AMP_W-1:0]    amplitude_reg;
    logic [fmtg_pkg::SCOUNT_W-1:0] sample_count_reg;

    // control and run state
    state_t                  state_reg;
    state_t                  state_next;
    logic                    running_reg;
    logic                    running_next;
    logic [COUNT_BITS-1:0]   sample_index_reg;
    logic [COUNT_BITS-1:0]   sample_index_next;
    logic                    last_pend_reg;
    logic                    last_pend_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    // datapath
    logic [PHASE_BITS-1:0]   carrier_phase_reg;
    logic [PHASE_BITS-1:0]   carrier_phase_next;
    logic [PHASE_BITS-1:0]   modulator_phase_reg;
    logic [PHASE_BITS-1:0]   modulator_phase_next;
    logic [PHASE_BITS-1:0]   offset_reg;
    logic [PHASE_BITS-1:0]   offset_next;
    logic [PHASE_BITS-1:0]   cphase_reg;
    logic [PHASE_BITS-1:0]   cphase_next;
    logic                    msign_reg;
    logic                    msign_next;
    logic signed [15:0]      sample_reg;
    logic signed [15:0]      sample_next;
    logic                    last_reg;
    logic                    last_next;

    // combinational helpers
    logic                    in_fire;
    logic                    run_eff;
    logic [COUNT_BITS-1:0]   idx_eff;
    logic [COUNT_BITS-1:0]   count;
    logic                    produce;
    logic                    fin;
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic signed [SN_W-1:0]  rom_data;
    logic signed [MP_W-1:0]  m_ext;
    logic [MP_W-1:0]         m_mag;
    logic                    mul_start;
    logic signed [MC_W-1:0]  mul_mcand;
    logic [MP_W-1:0]         mul_mplier;
    logic                    mul_done;
    logic signed [PR_W-1:0]  mul_product;
    logic signed [PR_W-1:0]  signed_mag;
    logic signed [OFF_W-1:0] off_ext;
    logic signed [PR_W-1:0]  rounded;
    logic signed [PR_W-1:0]  scaled;
    logic signed [15:0]      sat_sample;

    // sine table and shared multiplier
    fmtg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    fmtg_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_reg <= '0;
            mod_step_reg     <= '0;
            mod_index_reg    <= '0;
            amplitude_reg    <= fmtg_pkg::AMP_RESET;
            sample_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fmtg_pkg::REG_CARRIER_STEP: carrier_step_reg <= cfg_data;
                fmtg_pkg::REG_MOD_STEP:     mod_step_reg     <= cfg_data;
                fmtg_pkg::REG_MOD_INDEX:    mod_index_reg    <= cfg_data;
                fmtg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data[fmtg_pkg::AMP_W-1:0];
                fmtg_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[fmtg_pkg::SCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // run bookkeeping for the word on the input
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign count    = COUNT_BITS'(sample_count_reg);
    assign run_eff  = restart || running_reg;
    assign idx_eff  = restart ? '0 : sample_index_reg;
    assign produce  = run_eff && (idx_eff < count);
    assign fin      = ({1'b0, idx_eff} + (COUNT_BITS + 1)'(1)) >= {1'b0, count};

    // table address: modulator phase, or carrier phase plus offset
    assign rom_addr = (state_reg == S_LOOK_C)
                    ? cphase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]
                    : modulator_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];

    // magnitude of the modulator sine
    assign m_ext = {rom_data[SN_W-1], rom_data};
    assign m_mag = rom_data[SN_W-1] ? MP_W'(-m_ext) : MP_W'(m_ext);

    // multiplier operands: index by |m|, then carrier sine by gain
    assign mul_mcand  = (state_reg == S_ISSUE_M)
                      ? {{(MC_W - fmtg_pkg::INDEX_W){1'b0}}, mod_index_reg}
                      : {{(MC_W - SN_W){rom_data[SN_W-1]}}, rom_data};
    assign mul_mplier = (state_reg == S_ISSUE_M) ? m_mag : MP_W'(amplitude_reg);

    // phase offset: signed index product scaled to phase units, flooring
    assign signed_mag = msign_reg ? -mul_product : mul_product;
    assign off_ext    = {{PHASE_BITS{signed_mag[PR_W-1]}}, signed_mag} << PHASE_BITS;

    // rounding and saturation of the gain product
    assign rounded = mul_product + fmtg_pkg::ROUND_HALF;
    assign scaled  = rounded >>> fmtg_pkg::ROUND_SHIFT;
    always_comb
    begin
        if (scaled > fmtg_pkg::SAT_MAX)
        begin
            sat_sample = 16'sh7fff;
        end
        else if (scaled < fmtg_pkg::SAT_MIN)
        begin
            sat_sample = 16'sh8000;
        end
        else
        begin
            sat_sample = scaled[15:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next           = state_reg;
        running_next         = running_reg;
        sample_index_next    = sample_index_reg;
        last_pend_next       = last_pend_reg;
        out_valid_next       = out_valid_reg;
        carrier_phase_next   = carrier_phase_reg;
        modulator_phase_next = modulator_phase_reg;
        offset_next          = offset_reg;
        cphase_next          = cphase_reg;
        msign_next           = msign_reg;
        sample_next          = sample_reg;
        last_next            = last_reg;
        mul_start            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (restart)
                    begin
                        carrier_phase_next   = '0;
                        modulator_phase_next = '0;
                    end
                    running_next      = produce && !fin;
                    sample_index_next = produce ? idx_eff + COUNT_BITS'(1) : idx_eff;
                    last_pend_next    = fin;
                    if (produce)
                    begin
                        state_next = S_LOOK_M;
                    end
                end
            end
            S_LOOK_M:
            begin
                state_next = S_ISSUE_M;
            end
            S_ISSUE_M:
            begin
                mul_start  = 1'b1;
                msign_next = rom_data[SN_W-1];
                state_next = S_WAIT_M;
            end
            S_WAIT_M:
            begin
                if (mul_done)
                begin
                    offset_next = off_ext[OFF_LO + PHASE_BITS - 1 : OFF_LO];
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                cphase_next = carrier_phase_reg + offset_reg;
                state_next  = S_LOOK_C;
            end
            S_LOOK_C:
            begin
                state_next = S_ISSUE_C;
            end
            S_ISSUE_C:
            begin
                mul_start  = 1'b1;
                state_next = S_WAIT_C;
            end
            S_WAIT_C:
            begin
                if (mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    sample_next          = sat_sample;
                    last_next            = last_pend_reg;
                    carrier_phase_next   = carrier_phase_reg + PHASE_BITS'(carrier_step_reg);
                    modulator_phase_next = modulator_phase_reg + PHASE_BITS'(mod_step_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            running_reg         <= 1'b0;
            sample_index_reg    <= '0;
            last_pend_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
            carrier_phase_reg   <= '0;
            modulator_phase_reg <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            running_reg         <= running_next;
            sample_index_reg    <= sample_index_next;
            last_pend_reg       <= last_pend_next;
            out_valid_reg       <= out_valid_next;
            carrier_phase_reg   <= carrier_phase_next;
            modulator_phase_reg <= modulator_phase_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        cphase_reg <= cphase_next;
        msign_reg  <= msign_next;
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

endmodule
